/* rtl/vending_purchase_greedy_change_macros.svh */
// Assertion macros used by the checker file.
`ifndef VENDING_PURCHASE_GREEDY_CHANGE_MACROS_SVH
`define VENDING_PURCHASE_GREEDY_CHANGE_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define VPGC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vpgc assertion failed");

// next-cycle implication
`define VPGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vpgc assertion failed");

`endif

/* rtl/vpgc_pkg.sv */
// Shared constants, types and the control program of the vending purchase block.
package vpgc_pkg;

   localparam int NUM_PRODUCTS = 16;
   localparam int NUM_DENOMS   = 4;
   localparam int NUM_REGS     = 4;

   localparam int PROD_IW = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;
   localparam int DEN_IW  = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
   localparam int ADDR_W  = $clog2(NUM_REGS) + 2;
   localparam int UPC_W   = 5;

   localparam int VAL_W  = 16;
   localparam int CNT_W  = 8;
   localparam int PROD_W = VAL_W + CNT_W;
   localparam int DSUB_W = VAL_W + CNT_W - 1;
   localparam int BIT_W  = $clog2(CNT_W);

   // request functions
   localparam logic [1:0] F_LOAD = 2'd0;
   localparam logic [1:0] F_SET  = 2'd1;
   localparam logic [1:0] F_BUY  = 2'd2;

   // response status
   localparam logic [2:0] ST_SOLD      = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_NO_STOCK  = 3'd2;
   localparam logic [2:0] ST_NO_FUNDS  = 3'd3;
   localparam logic [2:0] ST_NO_CHANGE = 3'd4;
   localparam logic [2:0] ST_ACK       = 3'd5;

   // datapath operations
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_WR_SLOT   = 4'd1;
   localparam logic [3:0] OP_SET_COIN  = 4'd2;
   localparam logic [3:0] OP_SRCH_INIT = 4'd3;
   localparam logic [3:0] OP_SRCH_STEP = 4'd4;
   localparam logic [3:0] OP_CALC_REST = 4'd5;
   localparam logic [3:0] OP_DEN_MUL   = 4'd6;
   localparam logic [3:0] OP_TAKE_ALL  = 4'd7;
   localparam logic [3:0] OP_DIV_STEP  = 4'd8;
   localparam logic [3:0] OP_DEN_NEXT  = 4'd9;
   localparam logic [3:0] OP_COMMIT    = 4'd10;
   localparam logic [3:0] OP_EMIT      = 4'd11;

   // jump conditions
   localparam logic [3:0] C_NEVER     = 4'd0;
   localparam logic [3:0] C_NO_REQ    = 4'd1;
   localparam logic [3:0] C_IS_LOAD   = 4'd2;
   localparam logic [3:0] C_IS_SET    = 4'd3;
   localparam logic [3:0] C_IS_BUY    = 4'd4;
   localparam logic [3:0] C_OUT_BUSY  = 4'd5;
   localparam logic [3:0] C_HIT       = 4'd6;
   localparam logic [3:0] C_SRCH_MORE = 4'd7;
   localparam logic [3:0] C_NO_STOCK  = 4'd8;
   localparam logic [3:0] C_NO_FUNDS  = 4'd9;
   localparam logic [3:0] C_DEN_ZERO  = 4'd10;
   localparam logic [3:0] C_FITS      = 4'd11;
   localparam logic [3:0] C_DIV_MORE  = 4'd12;
   localparam logic [3:0] C_DEN_MORE  = 4'd13;
   localparam logic [3:0] C_REST_NZ   = 4'd14;

   typedef logic [NUM_DENOMS-1:0][VAL_W-1:0] denom_arr_type;

   typedef struct packed {
      logic [3:0]       op;
      logic [3:0]       cond;
      logic [UPC_W-1:0] tgt;
      logic             last;
      logic [2:0]       st;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic is_load;
      logic is_set;
      logic is_buy;
      logic out_busy;
      logic hit;
      logic srch_more;
      logic no_stock;
      logic no_funds;
      logic den_zero;
      logic fits;
      logic div_more;
      logic den_more;
      logic rest_nz;
   } flags_type;

   function automatic logic [VAL_W-1:0] denom_reset(input int i);
      case (i)
         0:       return 16'd1;
         1:       return 16'd5;
         2:       return 16'd10;
         3:       return 16'd50;
         default: return '0;
      endcase
   endfunction

   function automatic ctrl_type uword(input logic [3:0] op, input logic [3:0] cond,
                                      input int tgt, input logic last,
                                      input logic [2:0] st);
      ctrl_type w;
      w.op   = op;
      w.cond = cond;
      w.tgt  = UPC_W'(tgt);
      w.last = last;
      w.st   = st;
      return w;
   endfunction

   // control store
   function automatic ctrl_type ucode(input logic [UPC_W-1:0] pc);
      case (pc)
         5'd0:    return uword(OP_NONE,      C_NO_REQ,    0,  1'b0, ST_ACK);
         5'd1:    return uword(OP_NONE,      C_IS_LOAD,   5,  1'b0, ST_ACK);
         5'd2:    return uword(OP_NONE,      C_IS_SET,    7,  1'b0, ST_ACK);
         5'd3:    return uword(OP_NONE,      C_IS_BUY,    9,  1'b0, ST_ACK);
         5'd4:    return uword(OP_EMIT,      C_OUT_BUSY,  4,  1'b1, ST_ACK);
         5'd5:    return uword(OP_WR_SLOT,   C_NEVER,     0,  1'b0, ST_ACK);
         5'd6:    return uword(OP_EMIT,      C_OUT_BUSY,  6,  1'b1, ST_ACK);
         5'd7:    return uword(OP_SET_COIN,  C_NEVER,     0,  1'b0, ST_ACK);
         5'd8:    return uword(OP_EMIT,      C_OUT_BUSY,  8,  1'b1, ST_ACK);
         5'd9:    return uword(OP_SRCH_INIT, C_NEVER,     0,  1'b0, ST_ACK);
         5'd10:   return uword(OP_SRCH_STEP, C_HIT,       13, 1'b0, ST_ACK);
         5'd11:   return uword(OP_NONE,      C_SRCH_MORE, 10, 1'b0, ST_ACK);
         5'd12:   return uword(OP_EMIT,      C_OUT_BUSY,  12, 1'b1, ST_NOT_FOUND);
         5'd13:   return uword(OP_NONE,      C_NO_STOCK,  22, 1'b0, ST_ACK);
         5'd14:   return uword(OP_CALC_REST, C_NO_FUNDS,  23, 1'b0, ST_ACK);
         5'd15:   return uword(OP_DEN_MUL,   C_DEN_ZERO,  18, 1'b0, ST_ACK);
         5'd16:   return uword(OP_TAKE_ALL,  C_FITS,      18, 1'b0, ST_ACK);
         5'd17:   return uword(OP_DIV_STEP,  C_DIV_MORE,  17, 1'b0, ST_ACK);
         5'd18:   return uword(OP_DEN_NEXT,  C_DEN_MORE,  15, 1'b0, ST_ACK);
         5'd19:   return uword(OP_NONE,      C_REST_NZ,   24, 1'b0, ST_ACK);
         5'd20:   return uword(OP_COMMIT,    C_NEVER,     0,  1'b0, ST_ACK);
         5'd21:   return uword(OP_EMIT,      C_OUT_BUSY,  21, 1'b1, ST_SOLD);
         5'd22:   return uword(OP_EMIT,      C_OUT_BUSY,  22, 1'b1, ST_NO_STOCK);
         5'd23:   return uword(OP_EMIT,      C_OUT_BUSY,  23, 1'b1, ST_NO_FUNDS);
         5'd24:   return uword(OP_EMIT,      C_OUT_BUSY,  24, 1'b1, ST_NO_CHANGE);
         default: return uword(OP_NONE,      C_NEVER,     0,  1'b1, ST_ACK);
      endcase
   endfunction

endpackage

/* rtl/vpgc_csr.sv */
// Denomination value registers behind the APB-style port.
module vpgc_csr import vpgc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output denom_arr_type     denom
);

   denom_arr_type       denom_ff;
   logic [ADDR_W-3:0]   ridx;
   logic                wr_en;

   assign ridx   = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign denom  = denom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DENOMS; i++) begin
            denom_ff[i] <= denom_reset(i);
         end
      end else if (wr_en) begin
         for (int i = 0; i < NUM_DENOMS; i++) begin
            if (i < NUM_REGS && int'(ridx) == i) begin
               denom_ff[i] <= pwdata[VAL_W-1:0];
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
         if (i < NUM_REGS && int'(ridx) == i) begin
            prdata = 32'(denom_ff[i]);
         end
      end
   end

endmodule

/* rtl/vpgc_useq.sv */
// Step counter, control store and conditional jump logic.
module vpgc_useq import vpgc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl,
   output logic      idle
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             taken;

   assign ctrl = ucode(upc_ff);
   assign idle = (upc_ff == '0);

   always_comb begin
      case (ctrl.cond)
         C_NEVER:     taken = 1'b0;
         C_NO_REQ:    taken = flags.no_req;
         C_IS_LOAD:   taken = flags.is_load;
         C_IS_SET:    taken = flags.is_set;
         C_IS_BUY:    taken = flags.is_buy;
         C_OUT_BUSY:  taken = flags.out_busy;
         C_HIT:       taken = flags.hit;
         C_SRCH_MORE: taken = flags.srch_more;
         C_NO_STOCK:  taken = flags.no_stock;
         C_NO_FUNDS:  taken = flags.no_funds;
         C_DEN_ZERO:  taken = flags.den_zero;
         C_FITS:      taken = flags.fits;
         C_DIV_MORE:  taken = flags.div_more;
         C_DEN_MORE:  taken = flags.den_more;
         C_REST_NZ:   taken = flags.rest_nz;
         default:     taken = 1'b0;
      endcase
   end

   always_comb begin
      if (taken) begin
         upc_in = ctrl.tgt;
      end else if (ctrl.last) begin
         upc_in = '0;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= '0;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* rtl/vpgc_dp.sv */
// Datapath: product table, coin counts, greedy change unit and response register.
module vpgc_dp import vpgc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_type      ctrl,
   output flags_type     flags,
   input  denom_arr_type denom,
   input  logic          req_valid,
   input  logic          accept,
   input  logic [1:0]    req_func,
   input  logic [3:0]    req_slot,
   input  logic [15:0]   req_item_code,
   input  logic [15:0]   req_item_price,
   input  logic [7:0]    req_item_stock,
   input  logic [1:0]    req_denom_index,
   input  logic [7:0]    req_denom_count,
   input  logic [15:0]   req_budget,
   output logic          rsp_valid,
   output logic [2:0]    rsp_status,
   output logic [15:0]   rsp_change,
   input  logic          rsp_stall
);

   // product table
   logic [VAL_W-1:0] code_ff  [NUM_PRODUCTS];
   logic [VAL_W-1:0] price_ff [NUM_PRODUCTS];
   logic [CNT_W-1:0] stock_ff [NUM_PRODUCTS];
   logic [NUM_PRODUCTS-1:0] pvalid_ff;

   logic [CNT_W-1:0] coin_ff  [NUM_DENOMS];
   logic [CNT_W-1:0] trial_ff [NUM_DENOMS];

   // latched request
   logic [1:0]  func_ff;
   logic [3:0]  slot_ff;
   logic [15:0] icode_ff, iprice_ff, budget_ff;
   logic [7:0]  istock_ff, dcount_ff;
   logic [1:0]  didx_ff;

   logic [PROD_IW:0]    idx_ff;
   logic [DEN_IW-1:0]   j_ff;
   logic [VAL_W-1:0]    rest_ff, chg_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [BIT_W-1:0]    bit_ff;
   logic [CNT_W-1:0]    q_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff;
   logic [15:0]         rsp_change_ff;

   logic [PROD_IW-1:0]  sel;
   logic [VAL_W-1:0]    v_cur;
   logic [CNT_W-1:0]    cnt_cur;
   logic [DSUB_W-1:0]   dsub;
   logic                dfit;
   logic [CNT_W-1:0]    qn;
   logic                out_busy, emit_go;

   assign sel      = idx_ff[PROD_IW-1:0];
   assign v_cur    = denom[j_ff];
   assign cnt_cur  = trial_ff[j_ff];
   assign dsub     = DSUB_W'(v_cur) << bit_ff;
   assign dfit     = dsub <= DSUB_W'(rest_ff);
   assign qn       = dfit ? (q_ff | (CNT_W'(1) << bit_ff)) : q_ff;
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign emit_go  = (ctrl.op == OP_EMIT) && !out_busy;

   always_comb begin
      flags.no_req    = !req_valid;
      flags.is_load   = (func_ff == F_LOAD);
      flags.is_set    = (func_ff == F_SET);
      flags.is_buy    = (func_ff == F_BUY);
      flags.out_busy  = out_busy;
      flags.hit       = pvalid_ff[sel] && (code_ff[sel] == icode_ff);
      flags.srch_more = (32'(idx_ff) < NUM_PRODUCTS);
      flags.no_stock  = (stock_ff[sel] == '0);
      flags.no_funds  = (budget_ff < price_ff[sel]);
      flags.den_zero  = (v_cur == '0);
      flags.fits      = (prod_ff <= PROD_W'(rest_ff));
      flags.div_more  = (bit_ff != '0);
      flags.den_more  = (j_ff != '0);
      flags.rest_nz   = (rest_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         slot_ff   <= req_slot;
         icode_ff  <= req_item_code;
         iprice_ff <= req_item_price;
         istock_ff <= req_item_stock;
         didx_ff   <= req_denom_index;
         dcount_ff <= req_denom_count;
         budget_ff <= req_budget;
      end
   end

   // table payload
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_WR_SLOT && 32'(slot_ff) < NUM_PRODUCTS) begin
         code_ff[PROD_IW'(slot_ff)]  <= icode_ff;
         price_ff[PROD_IW'(slot_ff)] <= iprice_ff;
         stock_ff[PROD_IW'(slot_ff)] <= istock_ff;
      end else if (ctrl.op == OP_COMMIT) begin
         stock_ff[sel] <= stock_ff[sel] - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= '0;
      end else if (ctrl.op == OP_WR_SLOT && 32'(slot_ff) < NUM_PRODUCTS) begin
         pvalid_ff[PROD_IW'(slot_ff)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DENOMS; i++) begin
            coin_ff[i] <= '0;
         end
      end else if (ctrl.op == OP_SET_COIN && 32'(didx_ff) < NUM_DENOMS) begin
         coin_ff[DEN_IW'(didx_ff)] <= dcount_ff;
      end else if (ctrl.op == OP_COMMIT) begin
         for (int i = 0; i < NUM_DENOMS; i++) begin
            coin_ff[i] <= trial_ff[i];
         end
      end
   end

   // search and greedy change sequencing
   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_SRCH_INIT: begin
            idx_ff <= '0;
            j_ff   <= DEN_IW'(NUM_DENOMS - 1);
            for (int i = 0; i < NUM_DENOMS; i++) begin
               trial_ff[i] <= coin_ff[i];
            end
         end
         OP_SRCH_STEP: begin
            if (!flags.hit) begin
               idx_ff <= idx_ff + (PROD_IW + 1)'(1);
            end
         end
         OP_CALC_REST: begin
            rest_ff <= budget_ff - price_ff[sel];
            chg_ff  <= budget_ff - price_ff[sel];
         end
         OP_DEN_MUL: begin
            prod_ff <= PROD_W'(cnt_cur) * PROD_W'(v_cur);
         end
         OP_TAKE_ALL: begin
            if (flags.fits) begin
               rest_ff     <= rest_ff - prod_ff[VAL_W-1:0];
               trial_ff[j_ff] <= '0;
            end else begin
               // quotient is known to be below the coin count, so 8 bits do
               bit_ff <= BIT_W'(CNT_W - 1);
               q_ff   <= '0;
            end
         end
         OP_DIV_STEP: begin
            if (dfit) begin
               rest_ff <= rest_ff - dsub[VAL_W-1:0];
            end
            q_ff <= qn;
            if (bit_ff == '0) begin
               trial_ff[j_ff] <= cnt_cur - qn;
            end else begin
               bit_ff <= bit_ff - BIT_W'(1);
            end
         end
         OP_DEN_NEXT: begin
            j_ff <= j_ff - DEN_IW'(1);
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_status_ff <= ctrl.st;
         rsp_change_ff <= (ctrl.st == ST_SOLD) ? chg_ff : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_change = rsp_change_ff;

endmodule

/* rtl/vending_purchase_greedy_change.sv */
// Top level of the vending purchase block with greedy change.
//
// Request channel (req_*): one request per purchase-side action. func selects
// load product slot, set coin count or buy. A request is taken when req_valid
// is high and req_stall low; req_stall is high during reset and while a request is in work.
// Response channel (rsp_*): exactly one response (status, change) per request,
// held in an output register until taken (rsp_valid high, rsp_stall low).
// A new request is accepted while the last response still waits.
// Control: a 25-step program in a control store drives the datapath.
// Sequence: decode dispatches on func; a load writes the product slot and a set
// writes the coin count, each then emits its response. A buy searches the table
// slot by slot, checks stock and funds, and per denomination skips a zero value,
// takes all coins when they fit or else runs an 8-step restoring quotient, and
// finally checks the remaining change, commits and responds. One request at a time.
// Stall: when the response register is still full and stalled, the program
// holds at its response step; no state is lost.
// Reset: synchronous; clears product valid bits, coin counts and the program
// counter, and restores the denomination values to 1, 5, 10 and 50.
// CSR: four 16-bit denomination registers at byte addresses 0, 4, 8, 12.
module vending_purchase_greedy_change import vpgc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [3:0]        req_slot,
   input  logic [15:0]       req_item_code,
   input  logic [15:0]       req_item_price,
   input  logic [7:0]        req_item_stock,
   input  logic [1:0]        req_denom_index,
   input  logic [7:0]        req_denom_count,
   input  logic [15:0]       req_budget,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_change,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   ctrl_type      ctrl;
   flags_type     flags;
   denom_arr_type denom;
   logic          idle;
   logic          accept;

   // requests enter only at the wait step of the program, never in reset
   assign req_stall = reset || !idle;
   assign accept    = req_valid && idle && !reset;

   vpgc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .denom   (denom)
   );

   vpgc_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl),
      .idle  (idle)
   );

   vpgc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .flags           (flags),
      .denom           (denom),
      .req_valid       (req_valid),
      .accept          (accept),
      .req_func        (req_func),
      .req_slot        (req_slot),
      .req_item_code   (req_item_code),
      .req_item_price  (req_item_price),
      .req_item_stock  (req_item_stock),
      .req_denom_index (req_denom_index),
      .req_denom_count (req_denom_count),
      .req_budget      (req_budget),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_change      (rsp_change),
      .rsp_stall       (rsp_stall)
   );

endmodule

/* rtl/vpgc_checker.sv */
// Port-level checker for the vending purchase block, bound to the top level.
`include "vending_purchase_greedy_change_macros.svh"

module vpgc_checker import vpgc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [2:0]        rsp_status,
   input logic [15:0]       rsp_change
);

   // a taken request keeps the block busy in the cycle after it
   `VPGC_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

   // change only on a sale
   `VPGC_ASSERT_NOW(a_change_only_sold, rsp_valid && rsp_status != ST_SOLD, rsp_change == '0)

   // status stays within the defined codes
   `VPGC_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= ST_ACK)

   `VPGC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   `VPGC_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_status) && $stable(rsp_change))

endmodule

bind vending_purchase_greedy_change vpgc_checker u_vpgc_checker (.*);
